// File: rtl/psu_pkg.sv
// Shared types and constants for the particle swarm update block.
// No dependencies; imported by psu_mac and particle_swarm_update.
package psu_pkg;

  localparam int MUL_W = 18;
  localparam int ACC_W = 44;
  localparam int VEL_W = 24;
  localparam int POS_W = 6;
  localparam int FRAC_W = 17;
  localparam int FIT_W = 27;
  localparam int CFG_W = 24;
  localparam int CFG_AW = 3;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
  localparam logic signed [VEL_W-1:0] VEL_ONE = 24'sd65536;

  typedef enum logic [1:0] {
    DIM_A = 2'd0,
    DIM_B = 2'd1,
    DIM_C = 2'd2,
    DIM_D = 2'd3
  } dim_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_START_POS_A  = 3'd0,
    CFG_START_POS_B  = 3'd1,
    CFG_START_FRAC_C = 3'd2,
    CFG_START_FRAC_D = 3'd3,
    CFG_START_VEL_A  = 3'd4,
    CFG_START_VEL_B  = 3'd5,
    CFG_START_VEL_C  = 3'd6,
    CFG_START_VEL_D  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_VMUL1,
    S_VMUL2,
    S_VACC,
    S_VEL,
    S_POS,
    S_SQ,
    S_SQLAST,
    S_FIT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
    logic acc_shl;
  } mac_ctl_t;

endpackage

// File: rtl/psu_mac.sv
// Shared multiply-accumulate unit: registered 18x18 signed product and
// a 44-bit accumulator. Depends on psu_pkg.
module psu_mac import psu_pkg::*; (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] mul_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   addend;

  always_comb begin
    base   = ctl.acc_clr ? '0 : acc_r;
    addend = '0;
    if (ctl.acc_add) begin
      addend = ctl.acc_shl ? (ACC_W'(mul_r) <<< 32) : ACC_W'(mul_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_r <= op_a * op_b;
    end
    if (ctl.acc_clr || ctl.acc_add) begin
      acc_r <= base + addend;
    end
  end

  assign acc = acc_r;

endmodule

// File: rtl/particle_swarm_update.sv
// A restart transaction runs LOAD, SQ per dimension, SQLAST and FIT; a step transaction
// runs VMUL1, VMUL2, VACC, VEL and POS per dimension, then SQ, SQLAST and FIT, where it
// waits for a free output slot; in_ready returns the cycle the result is registered. One
// transaction at a time uses the single shared 18x18 multiplier for all products and squares.
// Reset (synchronous, rst_n low): particle state, best and score clear to zero,
// start registers clear except the two integer start velocities, which load 1.0.
module particle_swarm_update import psu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [FRAC_W-1:0]        in_own_weight,
  input  logic [FRAC_W-1:0]        in_swarm_weight_rand,
  input  logic signed [POS_W-1:0]  in_swarm_pos_a,
  input  logic signed [POS_W-1:0]  in_swarm_pos_b,
  input  logic [FRAC_W-1:0]        in_swarm_frac_c,
  input  logic [FRAC_W-1:0]        in_swarm_frac_d,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_pos_a,
  output logic signed [POS_W-1:0]  out_pos_b,
  output logic [FRAC_W-1:0]        out_frac_c,
  output logic [FRAC_W-1:0]        out_frac_d,
  output logic signed [FIT_W-1:0]  out_fitness,
  output logic                     out_improved
);

  function automatic logic signed [MUL_W-1:0] coord(
    input logic [1:0] k,
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b,
    input logic [FRAC_W-1:0] c,
    input logic [FRAC_W-1:0] d
  );
    case (k)
      DIM_A:   coord = MUL_W'(a);
      DIM_B:   coord = MUL_W'(b);
      DIM_C:   coord = $signed({1'b0, c});
      default: coord = $signed({1'b0, d});
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [8:0] p);
    if (p > 9'sd20) begin
      clamp_pos = 6'sd20;
    end else if (p < -9'sd20) begin
      clamp_pos = -6'sd20;
    end else begin
      clamp_pos = p[POS_W-1:0];
    end
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic signed [25:0] f);
    if (f < 26'sd0) begin
      clamp_frac = '0;
    end else if (f > 26'sd65536) begin
      clamp_frac = FRAC_ONE;
    end else begin
      clamp_frac = f[FRAC_W-1:0];
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [ACC_W:0] v);
    if (v > 45'sd8388607) begin
      sat_vel = 24'sh7FFFFF;
    end else if (v < -45'sd8388608) begin
      sat_vel = 24'sh800000;
    end else begin
      sat_vel = v[VEL_W-1:0];
    end
  endfunction

  state_t                  state_r, state_nxt;
  logic [1:0]              k_r;
  logic                    cmd_r;
  logic [FRAC_W-1:0]       r1_r, r2_r;
  logic signed [POS_W-1:0] sw_a_r, sw_b_r;
  logic [FRAC_W-1:0]       sw_c_r, sw_d_r;

  logic signed [POS_W-1:0] cfg_pos_a_r, cfg_pos_b_r;
  logic [FRAC_W-1:0]       cfg_frac_c_r, cfg_frac_d_r;
  logic signed [VEL_W-1:0] cfg_vel_r [4];

  logic signed [POS_W-1:0] pos_a_r, pos_b_r;
  logic [FRAC_W-1:0]       frac_c_r, frac_d_r;
  logic signed [VEL_W-1:0] vel_r [4];
  logic signed [POS_W-1:0] best_a_r, best_b_r;
  logic [FRAC_W-1:0]       best_c_r, best_d_r;
  logic signed [FIT_W-1:0] best_score_r;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_a_r, out_pos_b_r;
  logic [FRAC_W-1:0]       out_frac_c_r, out_frac_d_r;
  logic signed [FIT_W-1:0] out_fitness_r;
  logic                    out_improved_r;

  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0] acc;

  logic signed [MUL_W-1:0] cur_k, best_k, sw_k, diff1, diff2;
  logic signed [ACC_W-1:0] delta;
  logic signed [ACC_W:0]   vsum;
  logic signed [VEL_W-1:0] vel_new, vel_k;
  logic signed [8:0]       quot, pint;
  logic signed [25:0]      fsum;
  logic signed [POS_W-1:0] pos_new;
  logic [FRAC_W-1:0]       frac_new;
  logic [27:0]             fit_full;
  logic signed [FIT_W-1:0] fit_val;
  logic                    commit, better, take;
  logic                    accept;

  psu_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign accept = in_valid && in_ready;

  always_comb begin
    cur_k  = coord(k_r, pos_a_r, pos_b_r, frac_c_r, frac_d_r);
    best_k = coord(k_r, best_a_r, best_b_r, best_c_r, best_d_r);
    sw_k   = coord(k_r, sw_a_r, sw_b_r, sw_c_r, sw_d_r);
    diff1  = best_k - cur_k;
    diff2  = sw_k - cur_k;
    vel_k  = vel_r[k_r];

    delta   = k_r[1] ? (acc >>> 16) : acc;
    vsum    = (ACC_W+1)'(vel_k) + (ACC_W+1)'(delta);
    vel_new = sat_vel(vsum);

    quot = 9'($signed(vel_k[VEL_W-1:16]));
    if (vel_k[VEL_W-1] && (vel_k[15:0] != 16'd0)) begin
      quot = quot + 9'sd1;
    end
    pint     = 9'(cur_k) + quot;
    pos_new  = clamp_pos(pint);
    fsum     = 26'(cur_k) + 26'(vel_k);
    frac_new = clamp_frac(fsum);

    fit_full = 28'd0 - 28'(acc[ACC_W-1:16]);
    fit_val  = $signed(fit_full[FIT_W-1:0]);
    better   = fit_val > best_score_r;
    take     = !cmd_r || better;
    commit   = (state_r == S_FIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = in_command ? S_VMUL1 : S_LOAD;
      S_LOAD:   state_nxt = S_SQ;
      S_VMUL1:  state_nxt = S_VMUL2;
      S_VMUL2:  state_nxt = S_VACC;
      S_VACC:   state_nxt = S_VEL;
      S_VEL:    state_nxt = S_POS;
      S_POS:    state_nxt = (k_r == DIM_D) ? S_SQ : S_VMUL1;
      S_SQ:     state_nxt = (k_r == DIM_D) ? S_SQLAST : S_SQ;
      S_SQLAST: state_nxt = S_FIT;
      S_FIT:    if (commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mac_ctl  = '0;
    op_a     = cur_k;
    op_b     = cur_k;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_VMUL1: begin
        mac_ctl.mul_en = 1'b1;
        op_a           = $signed({1'b0, r1_r});
        op_b           = diff1;
      end
      S_VMUL2: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_clr = 1'b1;
        mac_ctl.acc_add = 1'b1;
        op_a            = $signed({1'b0, r2_r});
        op_b            = diff2;
      end
      S_VACC: begin
        mac_ctl.acc_add = 1'b1;
      end
      S_SQ: begin
        mac_ctl.mul_en = 1'b1;
        if (k_r == DIM_A) begin
          mac_ctl.acc_clr = 1'b1;
        end else begin
          mac_ctl.acc_add = 1'b1;
          mac_ctl.acc_shl = (k_r != DIM_D);
        end
      end
      S_SQLAST: begin
        mac_ctl.acc_add = 1'b1;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pos_a_r  <= '0;
      cfg_pos_b_r  <= '0;
      cfg_frac_c_r <= '0;
      cfg_frac_d_r <= '0;
      cfg_vel_r[0] <= VEL_ONE;
      cfg_vel_r[1] <= VEL_ONE;
      cfg_vel_r[2] <= '0;
      cfg_vel_r[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_POS_A:  cfg_pos_a_r  <= cfg_wdata[POS_W-1:0];
        CFG_START_POS_B:  cfg_pos_b_r  <= cfg_wdata[POS_W-1:0];
        CFG_START_FRAC_C: cfg_frac_c_r <= cfg_wdata[FRAC_W-1:0];
        CFG_START_FRAC_D: cfg_frac_d_r <= cfg_wdata[FRAC_W-1:0];
        CFG_START_VEL_A:  cfg_vel_r[0] <= cfg_wdata;
        CFG_START_VEL_B:  cfg_vel_r[1] <= cfg_wdata;
        CFG_START_VEL_C:  cfg_vel_r[2] <= cfg_wdata;
        CFG_START_VEL_D:  cfg_vel_r[3] <= cfg_wdata;
        default:          cfg_pos_a_r  <= cfg_pos_a_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      r1_r   <= in_own_weight;
      r2_r   <= in_swarm_weight_rand;
      sw_a_r <= in_swarm_pos_a;
      sw_b_r <= in_swarm_pos_b;
      sw_c_r <= in_swarm_frac_c;
      sw_d_r <= in_swarm_frac_d;
    end
    if (commit) begin
      out_pos_a_r    <= pos_a_r;
      out_pos_b_r    <= pos_b_r;
      out_frac_c_r   <= frac_c_r;
      out_frac_d_r   <= frac_d_r;
      out_fitness_r  <= fit_val;
      out_improved_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
      pos_a_r      <= '0;
      pos_b_r      <= '0;
      frac_c_r     <= '0;
      frac_d_r     <= '0;
      vel_r[0]     <= '0;
      vel_r[1]     <= '0;
      vel_r[2]     <= '0;
      vel_r[3]     <= '0;
      best_a_r     <= '0;
      best_b_r     <= '0;
      best_c_r     <= '0;
      best_d_r     <= '0;
      best_score_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept || (state_r == S_LOAD)) begin
        k_r <= '0;
      end else if ((state_r == S_POS) || (state_r == S_SQ)) begin
        k_r <= k_r + 2'd1;
      end

      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_LOAD) begin
        pos_a_r  <= clamp_pos(9'(cfg_pos_a_r));
        pos_b_r  <= clamp_pos(9'(cfg_pos_b_r));
        frac_c_r <= (cfg_frac_c_r > FRAC_ONE) ? FRAC_ONE : cfg_frac_c_r;
        frac_d_r <= (cfg_frac_d_r > FRAC_ONE) ? FRAC_ONE : cfg_frac_d_r;
        vel_r[0] <= (cfg_vel_r[0] == '0) ? VEL_ONE : cfg_vel_r[0];
        vel_r[1] <= (cfg_vel_r[1] == '0) ? VEL_ONE : cfg_vel_r[1];
        vel_r[2] <= cfg_vel_r[2];
        vel_r[3] <= cfg_vel_r[3];
      end

      if (state_r == S_VEL) begin
        vel_r[k_r] <= vel_new;
      end

      if (state_r == S_POS) begin
        case (k_r)
          DIM_A:   pos_a_r  <= pos_new;
          DIM_B:   pos_b_r  <= pos_new;
          DIM_C:   frac_c_r <= frac_new;
          default: frac_d_r <= frac_new;
        endcase
      end

      if (commit && take) begin
        best_a_r     <= pos_a_r;
        best_b_r     <= pos_b_r;
        best_c_r     <= frac_c_r;
        best_d_r     <= frac_d_r;
        best_score_r <= fit_val;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_a    = out_pos_a_r;
  assign out_pos_b    = out_pos_b_r;
  assign out_frac_c   = out_frac_c_r;
  assign out_frac_d   = out_frac_d_r;
  assign out_fitness  = out_fitness_r;
  assign out_improved = out_improved_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_a_r <= 6'sd20) && (pos_a_r >= -6'sd20) &&
    (pos_b_r <= 6'sd20) && (pos_b_r >= -6'sd20))
    else $error("integer coordinate left its clamp range");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (frac_c_r <= FRAC_ONE) && (frac_d_r <= FRAC_ONE))
    else $error("fractional coordinate above one");

  a_restart_improves: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !cmd_r) |=> out_improved_r)
    else $error("restart result not flagged as improved");

  a_best_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (!out_improved_r || (out_fitness_r == best_score_r)))
    else $error("improved result does not match stored best score");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("accepted a new transaction while busy");

endmodule

// File: dv/particle_swarm_update_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for particle_swarm_update: random valid/ready traffic, a predictor
// of the particle state, and an in-order check of every update. Depends on psu_pkg and the RTL.
module particle_swarm_update_tb;
  import psu_pkg::*;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam longint POS_LIM = 20;
  localparam longint FRAC_MAX = 65536;
  localparam longint VEL_HI = 8388607;
  localparam longint VEL_LO = -8388608;

  typedef struct {
    logic                    command;
    logic [FRAC_W-1:0]       own_weight;
    logic [FRAC_W-1:0]       social_weight;
    logic signed [POS_W-1:0] swarm_pos_a;
    logic signed [POS_W-1:0] swarm_pos_b;
    logic [FRAC_W-1:0]       swarm_frac_c;
    logic [FRAC_W-1:0]       swarm_frac_d;
  } psu_cmd_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;
    logic [FRAC_W-1:0]       frac_c;
    logic [FRAC_W-1:0]       frac_d;
    logic signed [FIT_W-1:0] fitness;
    logic                    improved;
  } psu_update_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_AW-1:0]       cfg_addr = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_command = 1'b0;
  logic [FRAC_W-1:0]       in_own_weight = '0;
  logic [FRAC_W-1:0]       in_swarm_weight_rand = '0;
  logic signed [POS_W-1:0] in_swarm_pos_a = '0;
  logic signed [POS_W-1:0] in_swarm_pos_b = '0;
  logic [FRAC_W-1:0]       in_swarm_frac_c = '0;
  logic [FRAC_W-1:0]       in_swarm_frac_d = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_pos_a;
  logic signed [POS_W-1:0] out_pos_b;
  logic [FRAC_W-1:0]       out_frac_c;
  logic [FRAC_W-1:0]       out_frac_d;
  logic signed [FIT_W-1:0] out_fitness;
  logic                    out_improved;

  particle_swarm_update i_dut (.*);

  always #5 clk = ~clk;

  // Start registers as last written, and the predicted particle state.
  logic [CFG_W-1:0] start_reg [8] = '{0, 0, 0, 0, 65536, 65536, 0, 0};
  longint p_pos [4];
  longint p_vel [4];
  longint p_best [4];
  longint p_best_fit;

  psu_cmd_t    command_q [$];
  psu_update_t update_q [$];
  psu_cmd_t    cmd_on_bus;
  psu_update_t got_upd;
  psu_update_t want_upd;
  bit          cmd_busy;
  bit          in_idle_en;
  bit          out_idle_en;
  int          in_gap;
  int          stall_left;
  int          mismatch_cnt;
  int          random_sent;
  int          mode;
  int          n_steps;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint neg_energy();
    longint ints;
    longint fr;
    ints = p_pos[DIM_A] * p_pos[DIM_A] + p_pos[DIM_B] * p_pos[DIM_B];
    fr = (p_pos[DIM_C] * p_pos[DIM_C] + p_pos[DIM_D] * p_pos[DIM_D]) >>> 16;
    return -(ints * 65536 + fr);
  endfunction

  function automatic psu_update_t advance_particle(input psu_cmd_t c);
    psu_update_t r;
    longint      fit;
    longint      sw [4];
    longint      d;
    longint      r1;
    longint      r2;
    bit          better;
    if (c.command == CMD_RESTART) begin
      p_pos[DIM_A] = clamp($signed(start_reg[CFG_START_POS_A][POS_W-1:0]), -POS_LIM, POS_LIM);
      p_pos[DIM_B] = clamp($signed(start_reg[CFG_START_POS_B][POS_W-1:0]), -POS_LIM, POS_LIM);
      p_pos[DIM_C] = clamp(longint'(start_reg[CFG_START_FRAC_C][FRAC_W-1:0]), 0, FRAC_MAX);
      p_pos[DIM_D] = clamp(longint'(start_reg[CFG_START_FRAC_D][FRAC_W-1:0]), 0, FRAC_MAX);
      for (int k = DIM_A; k <= DIM_D; k++) begin
        p_vel[k] = longint'($signed(start_reg[CFG_START_VEL_A + k]));
      end
      if (p_vel[DIM_A] == 0) p_vel[DIM_A] = 65536;
      if (p_vel[DIM_B] == 0) p_vel[DIM_B] = 65536;
      fit = neg_energy();
      better = 1'b1;
    end else begin
      r1 = longint'(c.own_weight);
      r2 = longint'(c.social_weight);
      sw[DIM_A] = longint'(c.swarm_pos_a);
      sw[DIM_B] = longint'(c.swarm_pos_b);
      sw[DIM_C] = longint'(c.swarm_frac_c);
      sw[DIM_D] = longint'(c.swarm_frac_d);
      for (int k = DIM_A; k <= DIM_D; k++) begin
        d = r1 * (p_best[k] - p_pos[k]) + r2 * (sw[k] - p_pos[k]);
        if (k >= DIM_C) d = d >>> 16;
        p_vel[k] = clamp(p_vel[k] + d, VEL_LO, VEL_HI);
      end
      for (int k = DIM_A; k <= DIM_B; k++) begin
        p_pos[k] = clamp(p_pos[k] + p_vel[k] / 65536, -POS_LIM, POS_LIM);
      end
      for (int k = DIM_C; k <= DIM_D; k++) begin
        p_pos[k] = clamp(p_pos[k] + p_vel[k], 0, FRAC_MAX);
      end
      fit = neg_energy();
      better = fit > p_best_fit;
    end
    if (better) begin
      for (int k = DIM_A; k <= DIM_D; k++) p_best[k] = p_pos[k];
      p_best_fit = fit;
    end
    r.pos_a = p_pos[DIM_A][POS_W-1:0];
    r.pos_b = p_pos[DIM_B][POS_W-1:0];
    r.frac_c = p_pos[DIM_C][FRAC_W-1:0];
    r.frac_d = p_pos[DIM_D][FRAC_W-1:0];
    r.fitness = fit[FIT_W-1:0];
    r.improved = better;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(9);
    if (r == 0) return POS_W'($urandom);
    if (r == 1) return POS_W'($urandom_range(1) ? 20 : -20);
    return POS_W'($urandom_range(40) - 20);
  endfunction

  function automatic logic [FRAC_W-1:0] rand_q16();
    int r;
    r = $urandom_range(9);
    if (r == 0) return FRAC_W'($urandom);
    if (r == 1) return FRAC_W'($urandom_range(1) ? 65536 : 0);
    return FRAC_W'($urandom_range(65536));
  endfunction

  function automatic psu_cmd_t mk_cmd(input logic cmd, input logic [FRAC_W-1:0] r1,
                                      input logic [FRAC_W-1:0] r2, input logic [POS_W-1:0] sa,
                                      input logic [POS_W-1:0] sb, input logic [FRAC_W-1:0] sc,
                                      input logic [FRAC_W-1:0] sd);
    psu_cmd_t c;
    c.command = cmd;
    c.own_weight = r1;
    c.social_weight = r2;
    c.swarm_pos_a = sa;
    c.swarm_pos_b = sb;
    c.swarm_frac_c = sc;
    c.swarm_frac_d = sd;
    return c;
  endfunction

  function automatic psu_cmd_t random_cmd(input logic cmd);
    return mk_cmd(cmd, rand_q16(), rand_q16(), rand_pos(), rand_pos(), rand_q16(), rand_q16());
  endfunction

  function automatic logic [CFG_W-1:0] pick_start(input cfg_idx_t idx);
    if ($urandom_range(3) == 0) return CFG_W'($urandom);
    case (idx)
      CFG_START_POS_A, CFG_START_POS_B: return CFG_W'(rand_pos());
      CFG_START_FRAC_C, CFG_START_FRAC_D: return CFG_W'(rand_q16());
      default: begin
        if ($urandom_range(2) != 0) return CFG_W'($urandom_range(262144) - 131072);
        case ($urandom_range(3))
          0: return '0;
          1: return 24'h7FFFFF;
          2: return 24'h800000;
          default: return VEL_ONE;
        endcase
      end
    endcase
  endfunction

  task automatic write_start_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    start_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (command_q.size() != 0 || cmd_busy || update_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Driver: present one command per transaction, with random gaps between them when in_idle_en is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_q.push_back(advance_particle(cmd_on_bus));
        cmd_busy = 1'b0;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (command_q.size() > 0) begin
          cmd_on_bus = command_q.pop_front();
          cmd_busy = 1'b1;
          in_command <= cmd_on_bus.command;
          in_own_weight <= cmd_on_bus.own_weight;
          in_swarm_weight_rand <= cmd_on_bus.social_weight;
          in_swarm_pos_a <= cmd_on_bus.swarm_pos_a;
          in_swarm_pos_b <= cmd_on_bus.swarm_pos_b;
          in_swarm_frac_c <= cmd_on_bus.swarm_frac_c;
          in_swarm_frac_d <= cmd_on_bus.swarm_frac_d;
          in_valid <= 1'b1;
          in_gap = in_idle_en ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each update transaction against the oldest prediction, stall at random when out_idle_en is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_upd.pos_a = out_pos_a;
        got_upd.pos_b = out_pos_b;
        got_upd.frac_c = out_frac_c;
        got_upd.frac_d = out_frac_d;
        got_upd.fitness = out_fitness;
        got_upd.improved = out_improved;
        if (update_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected update: pos %0d,%0d frac %0d,%0d fit %0d imp %0b",
                     got_upd.pos_a, got_upd.pos_b, got_upd.frac_c, got_upd.frac_d,
                     got_upd.fitness, got_upd.improved);
        end else begin
          want_upd = update_q.pop_front();
          if (got_upd.pos_a !== want_upd.pos_a || got_upd.pos_b !== want_upd.pos_b ||
              got_upd.frac_c !== want_upd.frac_c || got_upd.frac_d !== want_upd.frac_d ||
              got_upd.fitness !== want_upd.fitness ||
              got_upd.improved !== want_upd.improved) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("update mismatch at %0t", $realtime);
              $display("  exp pos %0d,%0d frac %0d,%0d fit %0d imp %0b",
                       want_upd.pos_a, want_upd.pos_b, want_upd.frac_c, want_upd.frac_d,
                       want_upd.fitness, want_upd.improved);
              $display("  got pos %0d,%0d frac %0d,%0d fit %0d imp %0b",
                       got_upd.pos_a, got_upd.pos_b, got_upd.frac_c, got_upd.frac_d,
                       got_upd.fitness, got_upd.improved);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(4) == 0) begin
        stall_left = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset start registers; step on the cleared state before any restart.
    command_q.push_back(mk_cmd(CMD_STEP, 17'h1FFFF, 17'h1FFFF, 6'h20, 6'h1F, 17'h1FFFF, 0));
    command_q.push_back(mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 0));
    command_q.push_back(random_cmd(CMD_RESTART));
    command_q.push_back(mk_cmd(CMD_STEP, 65536, 0, 20, -20, 65536, 65536));
    drain();

    // Out-of-range start positions, zero integer velocities, saturated fraction velocities.
    write_start_reg(CFG_START_POS_A, 24'h00001F);
    write_start_reg(CFG_START_POS_B, 24'hFFFFE0);
    write_start_reg(CFG_START_FRAC_C, 24'h01FFFF);
    write_start_reg(CFG_START_FRAC_D, 24'h000000);
    write_start_reg(CFG_START_VEL_A, 24'h000000);
    write_start_reg(CFG_START_VEL_B, 24'h000000);
    write_start_reg(CFG_START_VEL_C, 24'h7FFFFF);
    write_start_reg(CFG_START_VEL_D, 24'h800000);
    command_q.push_back(random_cmd(CMD_RESTART));
    command_q.push_back(mk_cmd(CMD_STEP, 0, 65536, 0, 0, 0, 17'h1FFFF));
    command_q.push_back(mk_cmd(CMD_STEP, 17'h1FFFF, 17'h1FFFF, 6'h20, 6'h20, 17'h1FFFF,
                               17'h1FFFF));
    command_q.push_back(mk_cmd(CMD_STEP, 32768, 32768, 20, 20, 32768, 32768));
    command_q.push_back(random_cmd(CMD_RESTART));
    drain();

    // In-range extremes with opposite saturated integer velocities.
    write_start_reg(CFG_START_POS_A, 24'hFFFFEC);
    write_start_reg(CFG_START_POS_B, 24'h000014);
    write_start_reg(CFG_START_FRAC_C, 24'h010000);
    write_start_reg(CFG_START_FRAC_D, 24'h010000);
    write_start_reg(CFG_START_VEL_A, 24'h800000);
    write_start_reg(CFG_START_VEL_B, 24'h7FFFFF);
    write_start_reg(CFG_START_VEL_C, 24'h000000);
    write_start_reg(CFG_START_VEL_D, 24'hFF0000);
    command_q.push_back(random_cmd(CMD_RESTART));
    command_q.push_back(mk_cmd(CMD_STEP, 65536, 65536, -20, 20, 0, 65536));
    command_q.push_back(mk_cmd(CMD_STEP, 1, 65535, 0, 0, 17'h1FFFF, 0));
    command_q.push_back(mk_cmd(CMD_STEP, 17'h15555, 17'h0AAAA, 6'h15, 6'h2A, 17'h15555,
                               17'h0AAAA));
    command_q.push_back(mk_cmd(CMD_STEP, 0, 0, 20, 20, 65536, 65536));
    command_q.push_back(random_cmd(CMD_RESTART));
    drain();

    // Random phases: new start registers, a restart, then a run of steps with occasional restarts.
    while (random_sent < 1850) begin
      mode = $urandom_range(3);
      in_idle_en = mode[0];
      out_idle_en = mode[1];
      for (int i = CFG_START_POS_A; i <= CFG_START_VEL_D; i++) begin
        write_start_reg(cfg_idx_t'(i), pick_start(cfg_idx_t'(i)));
      end
      n_steps = $urandom_range(90, 30);
      command_q.push_back(random_cmd(CMD_RESTART));
      for (int i = 0; i < n_steps; i++) begin
        command_q.push_back(random_cmd($urandom_range(19) == 0 ? CMD_RESTART : CMD_STEP));
      end
      random_sent += n_steps + 1;
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && update_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/psu_pkg.sv
rtl/psu_mac.sv
rtl/particle_swarm_update.sv
dv/particle_swarm_update_tb.sv
